FILE: hw/rtl/rps_pkg.sv
// Shared types and constants for the card shuffler.
`default_nettype none
package rps_pkg;

    localparam int MAX_CARDS_DEF = 64;
    localparam int WORD_W        = 32;
    localparam int STEP_W        = $clog2(WORD_W);
    localparam int DECK_W        = 7;
    localparam int CARD_OUT_W    = 6;
    localparam logic [DECK_W-1:0] DECK_RESET = 7'd52;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } rps_state_t;

    typedef struct packed {
        logic start;
    } rps_div_ctl_t;

    typedef struct packed {
        logic done;
    } rps_div_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rps_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rps_mod_serial.sv
// Bit-serial remainder unit: word modulo a small divisor, one bit per cycle.
`default_nettype none
module rps_mod_serial
    import rps_pkg::*;
#(
    parameter int MAX_CARDS = MAX_CARDS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rps_div_ctl_t                     ctl,
    input  wire logic [WORD_W-1:0]                dividend,
    input  wire logic [$clog2(MAX_CARDS+1)-1:0]   divisor,
    output rps_div_sts_t                          sts,
    output logic      [$clog2(MAX_CARDS+1)-1:0]   remainder
);

    localparam int CNT_W = $clog2(MAX_CARDS + 1);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        word_next = word_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // Shift in the next dividend bit and subtract if it fits.
        trial     = {rem_reg, word_reg[WORD_W-1]};
        if (ctl.start)
        begin
            word_next = dividend;
            div_next  = divisor;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            word_next = {word_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            if (step_reg == STEP_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/random_permutation_shuffler_top.sv
// Top level of the Fisher-Yates card shuffler.
//
// Each accepted word carries a 32-bit random value and yields one card. A round
// deals cards 0..S-1 once each, S being deck_size (zero taken as 1, anything
// above MAX_CARDS taken as MAX_CARDS) latched when the round's first word
// arrives; deck_size written mid-round waits for the next round. The drawn
// position is the random value modulo the live count, with the usual small
// bias. The card there goes out, the last live pool entry moves into its slot
// and the count drops; last_card marks the round's final card. After an accept
// the bit-serial remainder unit takes one dividend bit per cycle and then flags
// done; the pool read follows, then the swap write that also loads the card;
// only then is in_ready back high for the next word, so one word is worked at a
// time. The write also waits while the previous card still sits unclaimed in
// the output register. The pool lives in a RAM; a vector of valid flags, all
// cleared together at each round start, makes an unwritten slot read as its own
// index, so no refill sweep is needed. cfg_ready is always high.
`default_nettype none
module random_permutation_shuffler_top
    import rps_pkg::*;
#(
    parameter int MAX_CARDS = MAX_CARDS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [DECK_W-1:0]     deck_size,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WORD_W-1:0]     random_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [CARD_OUT_W-1:0] card,
    output logic                       last_card
);

    localparam int CARD_W = $clog2(MAX_CARDS);
    localparam int CNT_W  = $clog2(MAX_CARDS + 1);

    rps_state_t            state_reg, state_next;
    logic [DECK_W-1:0]     deck_reg, deck_next;
    logic [CNT_W-1:0]      remaining_reg, remaining_next;
    logic [MAX_CARDS-1:0]  valid_reg, valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CARD_OUT_W-1:0] card_reg, card_next;
    logic                  last_reg, last_next;

    rps_div_ctl_t          div_ctl;
    rps_div_sts_t          div_sts;
    logic [CNT_W-1:0]      divisor;
    logic [CNT_W-1:0]      rem;
    logic [CNT_W-1:0]      eff_size;
    logic [CNT_W-1:0]      last_idx;
    logic [CARD_W-1:0]     pos;
    logic [CARD_W-1:0]     last_pos;
    logic                  ram_we;
    logic [CARD_W-1:0]     q_pos, q_last;
    logic [CARD_W-1:0]     card_val, last_val;
    logic                  in_acc, out_free;

    // Saturate the configured deck size into 1..MAX_CARDS.
    always_comb
    begin
        if (deck_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (32'(deck_reg) > MAX_CARDS)
        begin
            eff_size = CNT_W'(MAX_CARDS);
        end
        else
        begin
            eff_size = CNT_W'(deck_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign divisor   = (remaining_reg == '0) ? eff_size : remaining_reg;
    assign last_idx  = remaining_reg - CNT_W'(1);
    assign pos       = rem[CARD_W-1:0];
    assign last_pos  = last_idx[CARD_W-1:0];

    // Slots not yet written this round hold their own index.
    assign card_val  = valid_reg[pos] ? q_pos : pos;
    assign last_val  = valid_reg[last_pos] ? q_last : last_pos;
    assign ram_we    = (state_reg == ST_WRITE) && out_free;

    assign div_ctl.start = in_acc;

    rps_mod_serial #(
        .MAX_CARDS (MAX_CARDS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (random_word),
        .divisor   (divisor),
        .sts       (div_sts),
        .remainder (rem)
    );

    rps_ram #(
        .WIDTH (CARD_W),
        .DEPTH (MAX_CARDS)
    ) u_pool (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (pos),
        .wdata   (last_val),
        .raddr_a (pos),
        .raddr_b (last_pos),
        .rdata_a (q_pos),
        .rdata_b (q_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deck_reg      <= DECK_RESET;
            remaining_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deck_reg      <= deck_next;
            remaining_reg <= remaining_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        card_reg <= card_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        deck_next      = deck_reg;
        remaining_next = remaining_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        card_next      = card_reg;
        last_next      = last_reg;

        if (cfg_valid && cfg_ready)
        begin
            deck_next = deck_size;
        end

        // Drop the output word once the sink takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // New round: latch the size and forget all pool writes.
                    if (remaining_reg == '0)
                    begin
                        remaining_next = eff_size;
                        valid_next     = '0;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Hold until the output register is free, then swap and emit.
                if (out_free)
                begin
                    valid_next[pos] = 1'b1;
                    card_next       = CARD_OUT_W'(card_val);
                    last_next       = (last_idx == '0);
                    out_valid_next  = 1'b1;
                    remaining_next  = last_idx;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign card      = card_reg;
    assign last_card = last_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rps_checker.sv
// Port-level checks for the card shuffler, bound to the top level.
`default_nettype none
module rps_checker
    import rps_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [CARD_OUT_W-1:0] card,
    input wire logic                  last_card
);

    // A stalled output word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(card) && $stable(last_card))
        else $error("output word changed while stalled");

    // One item at a time: input closes right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after accept");

    // A new card never appears the cycle after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("card produced too early");

    // A card only emerges after the input was closed for the work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("card produced while input open");

endmodule

bind random_permutation_shuffler_top rps_checker u_rps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .card      (card),
    .last_card (last_card)
);
`default_nettype wire
